@@ sv/ipatp_pkg.sv @@
// shared types and constants for the ip address text parser
package ipatp_pkg;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_LEAD  = 3'd1,
        PH_HEX   = 3'd2,
        PH_COLON = 3'd3,
        PH_GAP   = 3'd4,
        PH_DOT   = 3'd5,
        PH_DEC   = 3'd6,
        PH_DONE  = 3'd7
    } phase_t;

    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;

    localparam logic [16:0] HEX_MAX = 17'h0ffff;
    localparam logic [16:0] HEX_SAT = 17'h10000;
    localparam logic [8:0]  DEC_MAX = 9'd255;
    localparam logic [8:0]  DEC_SAT = 9'd256;
    localparam logic [3:0]  NUM_GROUPS = 4'd8;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [7:0][15:0] groups;
        logic [3:0]       group_count;
        logic [3:0]       gap_position;
        logic             gap_seen;
        logic [16:0]      hex_accum;
        logic [8:0]       dec_accum;
        logic [31:0]      octets;
        logic [1:0]       octet_index;
        phase_t           phase;
        logic             letter;
        logic             v6_failed;
        logic             v4_failed;
    } scan_state_t;

    typedef struct packed {
        logic [63:0] addr_lo;
        logic [63:0] addr_hi;
        logic [1:0]  family;
        logic        ok;
    } result_t;

endpackage

@@ sv/ipatp_scan.sv @@
// per-character scanner: live parse state and its one-character update
module ipatp_scan
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  beat,
    input  logic                  last,
    input  logic [7:0]            ch,
    output ipatp_pkg::scan_state_t scanned
);
    import ipatp_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t upd;

    logic        is_dec;
    logic        is_alpha;
    logic        hv_ok;
    logic [3:0]  hv;
    logic        ws;
    logic [20:0] hex_wide;
    logic [16:0] hex_step;
    logic [11:0] dec_wide;
    logic [8:0]  dec_step;

    function automatic logic [31:0] place_octet(input logic [7:0] v, input logic [1:0] idx);
        logic [31:0] r;
        begin
            r = '0;
            case (idx)
                2'd0:    r[31:24] = v;
                2'd1:    r[23:16] = v;
                2'd2:    r[15:8]  = v;
                default: r[7:0]   = v;
            endcase
            return r;
        end
    endfunction

    always_comb
    begin
        is_dec   = (ch >= 8'h30) && (ch <= 8'h39);
        is_alpha = ((ch >= 8'h61) && (ch <= 8'h66)) || ((ch >= 8'h41) && (ch <= 8'h46));
        hv_ok    = is_dec || is_alpha;
        hv       = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);
        ws       = (ch == CH_SPACE) || (ch == CH_TAB);
        hex_wide = {state_reg.hex_accum, 4'b0} + {17'b0, hv};
        hex_step = (hex_wide > {4'b0, HEX_SAT}) ? HEX_SAT : hex_wide[16:0];
        dec_wide = {state_reg.dec_accum, 3'b0} + {2'b0, state_reg.dec_accum, 1'b0}
                 + {8'b0, ch[3:0]};
        dec_step = (dec_wide > {3'b0, DEC_SAT}) ? DEC_SAT : dec_wide[8:0];
    end

    always_comb
    begin
        upd = state_reg;
        if (!(state_reg.v4_failed && state_reg.v6_failed))
        begin
            unique case (state_reg.phase)
                PH_START:
                begin
                    if (hv_ok)
                    begin
                        upd.hex_accum = {13'b0, hv};
                        upd.dec_accum = is_dec ? {5'b0, hv} : 9'd0;
                        upd.phase     = PH_HEX;
                        upd.letter    = !is_dec;
                    end
                    else if (ch == CH_COLON)
                    begin
                        upd.v4_failed = 1'b1;
                        upd.phase     = PH_LEAD;
                        upd.letter    = 1'b0;
                    end
                    else
                    begin
                        upd.v4_failed = 1'b1;
                        upd.v6_failed = 1'b1;
                    end
                end
                PH_LEAD:
                begin
                    if (ch == CH_COLON)
                    begin
                        upd.gap_seen     = 1'b1;
                        upd.gap_position = 4'd0;
                        upd.phase        = PH_GAP;
                        upd.letter       = 1'b0;
                    end
                    else
                    begin
                        upd.v4_failed = 1'b1;
                        upd.v6_failed = 1'b1;
                    end
                end
                PH_HEX:
                begin
                    if (hv_ok)
                    begin
                        upd.hex_accum = hex_step;
                        if (is_dec)
                        begin
                            upd.dec_accum = dec_step;
                        end
                        else
                        begin
                            upd.letter = 1'b1;
                        end
                    end
                    else if (ch == CH_COLON)
                    begin
                        upd.v4_failed = 1'b1;
                        if ((state_reg.hex_accum > HEX_MAX) ||
                            (state_reg.group_count >= NUM_GROUPS))
                        begin
                            upd.v6_failed = 1'b1;
                        end
                        else
                        begin
                            upd.groups[state_reg.group_count[2:0]] = state_reg.hex_accum[15:0];
                            upd.group_count = state_reg.group_count + 4'd1;
                        end
                        upd.phase  = PH_COLON;
                        upd.letter = 1'b0;
                    end
                    else if (ch == CH_DOT)
                    begin
                        if (state_reg.letter || (state_reg.dec_accum > DEC_MAX))
                        begin
                            upd.v4_failed = 1'b1;
                            upd.v6_failed = 1'b1;
                        end
                        else
                        begin
                            if (state_reg.group_count > 4'd6)
                            begin
                                upd.v6_failed = 1'b1;
                            end
                            upd.octets      = place_octet(state_reg.dec_accum[7:0], 2'd0);
                            upd.octet_index = 2'd1;
                            upd.phase       = PH_DOT;
                            upd.letter      = 1'b0;
                        end
                    end
                    else
                    begin
                        upd.v4_failed = 1'b1;
                        upd.v6_failed = 1'b1;
                    end
                end
                PH_COLON, PH_GAP:
                begin
                    if (hv_ok)
                    begin
                        if (state_reg.group_count >= NUM_GROUPS)
                        begin
                            upd.v6_failed = 1'b1;
                        end
                        upd.hex_accum = {13'b0, hv};
                        upd.dec_accum = is_dec ? {5'b0, hv} : 9'd0;
                        upd.phase     = PH_HEX;
                        upd.letter    = !is_dec;
                    end
                    else if ((ch == CH_COLON) && (state_reg.phase == PH_COLON))
                    begin
                        if (state_reg.gap_seen)
                        begin
                            upd.v6_failed = 1'b1;
                        end
                        else
                        begin
                            upd.gap_seen     = 1'b1;
                            upd.gap_position = state_reg.group_count;
                        end
                        upd.phase  = PH_GAP;
                        upd.letter = 1'b0;
                    end
                    else
                    begin
                        upd.v4_failed = 1'b1;
                        upd.v6_failed = 1'b1;
                    end
                end
                PH_DOT:
                begin
                    if (is_dec)
                    begin
                        upd.dec_accum = {5'b0, ch[3:0]};
                        upd.phase     = PH_DEC;
                        upd.letter    = 1'b0;
                    end
                    else
                    begin
                        upd.v4_failed = 1'b1;
                        upd.v6_failed = 1'b1;
                    end
                end
                PH_DEC:
                begin
                    if (is_dec)
                    begin
                        upd.dec_accum = dec_step;
                    end
                    else if ((ch == CH_DOT) && (state_reg.dec_accum <= DEC_MAX) &&
                             (state_reg.octet_index < 2'd3))
                    begin
                        upd.octets = state_reg.octets |
                                     place_octet(state_reg.dec_accum[7:0], state_reg.octet_index);
                        upd.octet_index = state_reg.octet_index + 2'd1;
                        upd.phase       = PH_DOT;
                        upd.letter      = 1'b0;
                    end
                    else if (ws && (state_reg.dec_accum <= DEC_MAX) &&
                             (state_reg.octet_index == 2'd3))
                    begin
                        upd.octets = state_reg.octets |
                                     place_octet(state_reg.dec_accum[7:0], state_reg.octet_index);
                        upd.phase  = PH_DONE;
                        upd.letter = 1'b0;
                    end
                    else
                    begin
                        upd.v4_failed = 1'b1;
                        upd.v6_failed = 1'b1;
                    end
                end
                default:
                begin
                    upd = state_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (beat)
        begin
            state_next = last ? '0 : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign scanned = upd;

endmodule

@@ sv/ipatp_finish.sv @@
// end-of-string checks, gap expansion and result formatting
module ipatp_finish
(
    input  ipatp_pkg::scan_state_t snap,
    output ipatp_pkg::result_t     res
);
    import ipatp_pkg::*;

    logic [7:0][15:0] grp;
    logic [7:0][15:0] list;
    logic [7:0][15:0] w;
    logic [3:0]       gc;
    logic [31:0]      oct;
    logic             v4ok;
    logic             v6ok;
    logic             tail;
    logic [3:0]       count;
    logic [3:0]       fill;
    logic [4:0]       gap_end;
    logic [2:0]       src;

    always_comb
    begin
        grp  = snap.groups;
        gc   = snap.group_count;
        oct  = snap.octets;
        v4ok = !snap.v4_failed;
        v6ok = !snap.v6_failed;
        tail = 1'b0;
        unique case (snap.phase)
            PH_HEX:
            begin
                v4ok = 1'b0;
                if ((snap.hex_accum > HEX_MAX) || (snap.group_count >= NUM_GROUPS))
                begin
                    v6ok = 1'b0;
                end
                else
                begin
                    grp[snap.group_count[2:0]] = snap.hex_accum[15:0];
                    gc = snap.group_count + 4'd1;
                end
            end
            PH_DEC:
            begin
                if ((snap.dec_accum <= DEC_MAX) && (snap.octet_index == 2'd3))
                begin
                    oct  = snap.octets | {24'b0, snap.dec_accum[7:0]};
                    tail = 1'b1;
                end
                else
                begin
                    v4ok = 1'b0;
                    v6ok = 1'b0;
                end
            end
            PH_DONE:
            begin
                tail = 1'b1;
            end
            PH_GAP:
            begin
                v4ok = 1'b0;
            end
            default:
            begin
                v4ok = 1'b0;
                v6ok = 1'b0;
            end
        endcase
        v4ok  = v4ok && tail;
        count = gc + (tail ? 4'd2 : 4'd0);
        if (snap.gap_seen)
        begin
            if (count > 4'd7)
            begin
                v6ok = 1'b0;
            end
        end
        else if (count != NUM_GROUPS)
        begin
            v6ok = 1'b0;
        end

        list = grp;
        if (tail && (gc <= 4'd6))
        begin
            list[gc[2:0]]        = oct[31:16];
            list[gc[2:0] + 3'd1] = oct[15:0];
        end
        fill    = snap.gap_seen ? (NUM_GROUPS - count) : 4'd0;
        gap_end = {1'b0, snap.gap_position} + {1'b0, fill};
        for (int i = 0; i < 8; i++)
        begin
            src = 3'(i) - fill[2:0];
            if (!snap.gap_seen || (5'(i) < {1'b0, snap.gap_position}))
            begin
                w[i] = list[i];
            end
            else if (5'(i) < gap_end)
            begin
                w[i] = 16'd0;
            end
            else
            begin
                w[i] = list[src];
            end
        end

        res = '0;
        if (v6ok)
        begin
            res.family  = FAM_V6;
            res.addr_hi = {w[0], w[1], w[2], w[3]};
            res.addr_lo = {w[4], w[5], w[6], w[7]};
        end
        else if (v4ok)
        begin
            res.family  = FAM_V4;
            res.addr_lo = {32'b0, oct};
        end
        res.ok = (res.family != FAM_NONE);
    end

endmodule

@@ sv/ip_address_text_parser_unit.sv @@
// top level of the ip address text parser: stream ports, end-of-string stage, result register
// Takes one character per beat and can take a character in every cycle while not held off.
// The beat with tlast set ends the string; its state is captured in an end-of-string register
// and the result (IPv6 tried first, then dotted IPv4, else invalid with all fields zero) is
// passed on through the result register to the output. That beat clears the scanner state, so
// the next accepted beat starts the next string. Any input beat is held off, but only while the
// end-of-string register is full and the result register holds a beat that is not being taken.
module ip_address_text_parser_unit
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // ch[7:0]
    input  logic           s_tlast,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [135:0]   m_tdata    // ok, family[2:1], addr_hi[66:3], addr_lo[130:67], zero
);
    import ipatp_pkg::*;

    logic         beat;
    logic         out_free;
    scan_state_t  scanned;
    scan_state_t  snap_reg;
    scan_state_t  snap_next;
    logic         snap_valid_reg;
    logic         snap_valid_next;
    result_t      res;
    result_t      out_reg;
    result_t      out_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !snap_valid_reg || out_free;
    assign beat     = s_tvalid && s_tready;

    ipatp_scan u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .last    (s_tlast),
        .ch      (s_tdata),
        .scanned (scanned)
    );

    ipatp_finish u_finish
    (
        .snap (snap_reg),
        .res  (res)
    );

    always_comb
    begin
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        if (out_free)
        begin
            out_valid_next  = snap_valid_reg;
            out_next        = res;
            snap_valid_next = 1'b0;
        end
        if (beat && s_tlast)
        begin
            snap_next       = scanned;
            snap_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.addr_lo, out_reg.addr_hi, out_reg.family, out_reg.ok};

`ifndef ASSERT_OFF
    a_ok_matches_family: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != FAM_NONE)))
        else $error("ok flag disagrees with family");

    a_family_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:1] == FAM_NONE || m_tdata[2:1] == FAM_V4 ||
                      m_tdata[2:1] == FAM_V6))
        else $error("unknown family code");

    a_v4_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:1] != FAM_V6) |-> (m_tdata[66:3] == 64'd0 &&
                                                  m_tdata[130:99] == 32'd0))
        else $error("ipv4 or invalid result carries high address bits");

    a_snap_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && s_tlast) |-> (!snap_valid_reg || out_free))
        else $error("end-of-string register overwritten");
`endif

endmodule

@@ verif/ipatp_check_pkg.sv @@
`timescale 1ns / 100ps
// scoreboard for the ip address text parser: address predictor and result beat check
package ipatp_check_pkg;
    import ipatp_pkg::*;

    class addr_parse_scoreboard;
        logic [15:0] grp[8];
        logic [3:0]  grp_cnt;
        logic [3:0]  gap_at;
        logic        gap_hit;
        logic [16:0] hex_run;
        logic [8:0]  dec_run;
        logic [31:0] quad;
        logic [1:0]  quad_idx;
        phase_t      phase;
        logic        hex_letter;
        logic        v6_bad;
        logic        v4_bad;
        result_t     want_q[$];
        int          errors = 0;
        int          strings = 0;
        int          chars = 0;
        int          n_v6 = 0;
        int          n_v4 = 0;
        int          n_bad = 0;

        function new();
            clear();
        endfunction

        function void clear();
            foreach (grp[i])
                grp[i] = 16'h0;
            grp_cnt = 4'd0;
            gap_at = 4'd0;
            gap_hit = 1'b0;
            hex_run = 17'd0;
            dec_run = 9'd0;
            quad = 32'd0;
            quad_idx = 2'd0;
            phase = PH_START;
            hex_letter = 1'b0;
            v6_bad = 1'b0;
            v4_bad = 1'b0;
        endfunction

        function void fail_both();
            v4_bad = 1'b1;
            v6_bad = 1'b1;
        endfunction

        function void start_run(int v, bit dec);
            hex_run = 17'(v);
            dec_run = dec ? 9'(v) : 9'd0;
            phase = PH_HEX;
            hex_letter = !dec;
        endfunction

        function void close_group();
            if (hex_run > HEX_MAX || grp_cnt >= NUM_GROUPS)
                v6_bad = 1'b1;
            else
            begin
                grp[grp_cnt[2:0]] = hex_run[15:0];
                grp_cnt++;
            end
        endfunction

        function void dec_push(int v);
            int unsigned d;
            d = int'(dec_run) * 10 + v;
            dec_run = (d > DEC_SAT) ? DEC_SAT : 9'(d);
        endfunction

        function void put_octet();
            quad = quad | (32'(dec_run[7:0]) << (24 - 8 * int'(quad_idx)));
        endfunction

        // one accepted character beat; a final beat queues the expected result
        function void note_beat(logic [7:0] c, logic last);
            int          hv;
            int unsigned h;
            bit          is_dec;
            bit          ws;
            bit          lt;
            bit          v4ok;
            bit          v6ok;
            bit          tail;
            int          cnt;
            int          fill;
            logic [15:0] lst[8];
            logic [15:0] w[8];
            logic [63:0] hi;
            logic [63:0] lo;
            logic [1:0]  fam;
            result_t     r;

            chars++;
            if (!(v4_bad && v6_bad))
            begin
                hv = -1;
                if (c >= 8'h30 && c <= 8'h39)
                    hv = int'(c) - 48;
                else if (c >= 8'h61 && c <= 8'h66)
                    hv = int'(c) - 87;
                else if (c >= 8'h41 && c <= 8'h46)
                    hv = int'(c) - 55;
                is_dec = (c >= 8'h30 && c <= 8'h39);
                ws = (c == CH_SPACE || c == CH_TAB);
                lt = hex_letter;
                case (phase)
                    PH_START:
                        if (hv >= 0)
                            start_run(hv, is_dec);
                        else if (c == CH_COLON)
                        begin
                            v4_bad = 1'b1;
                            phase = PH_LEAD;
                            hex_letter = 1'b0;
                        end
                        else
                            fail_both();
                    PH_LEAD:
                        if (c == CH_COLON)
                        begin
                            gap_hit = 1'b1;
                            gap_at = 4'd0;
                            phase = PH_GAP;
                            hex_letter = 1'b0;
                        end
                        else
                            fail_both();
                    PH_HEX:
                        if (hv >= 0)
                        begin
                            h = int'(hex_run) * 16 + hv;
                            hex_run = (h > HEX_SAT) ? HEX_SAT : 17'(h);
                            if (is_dec)
                                dec_push(hv);
                            else
                                lt = 1'b1;
                            hex_letter = lt;
                        end
                        else if (c == CH_COLON)
                        begin
                            v4_bad = 1'b1;
                            close_group();
                            phase = PH_COLON;
                            hex_letter = 1'b0;
                        end
                        else if (c == CH_DOT)
                        begin
                            // run before the first dot becomes the first tail octet
                            if (hex_letter || dec_run > DEC_MAX)
                                fail_both();
                            else
                            begin
                                if (grp_cnt > 4'd6)
                                    v6_bad = 1'b1;
                                quad = 32'd0;
                                quad_idx = 2'd0;
                                put_octet();
                                quad_idx = 2'd1;
                                phase = PH_DOT;
                                hex_letter = 1'b0;
                            end
                        end
                        else
                            fail_both();
                    PH_COLON:
                        if (hv >= 0)
                        begin
                            if (grp_cnt >= NUM_GROUPS)
                                v6_bad = 1'b1;
                            start_run(hv, is_dec);
                        end
                        else if (c == CH_COLON)
                        begin
                            if (gap_hit)
                                v6_bad = 1'b1;
                            else
                            begin
                                gap_hit = 1'b1;
                                gap_at = grp_cnt;
                            end
                            phase = PH_GAP;
                            hex_letter = 1'b0;
                        end
                        else
                            fail_both();
                    PH_GAP:
                        if (hv >= 0)
                        begin
                            if (grp_cnt >= NUM_GROUPS)
                                v6_bad = 1'b1;
                            start_run(hv, is_dec);
                        end
                        else
                            fail_both();
                    PH_DOT:
                        if (is_dec)
                        begin
                            dec_run = 9'(hv);
                            phase = PH_DEC;
                            hex_letter = 1'b0;
                        end
                        else
                            fail_both();
                    PH_DEC:
                        if (is_dec)
                            dec_push(hv);
                        else if (c == CH_DOT)
                        begin
                            if (dec_run > DEC_MAX || quad_idx >= 2'd3)
                                fail_both();
                            else
                            begin
                                put_octet();
                                quad_idx++;
                                phase = PH_DOT;
                                hex_letter = 1'b0;
                            end
                        end
                        else if (ws)
                        begin
                            if (dec_run > DEC_MAX || quad_idx != 2'd3)
                                fail_both();
                            else
                            begin
                                put_octet();
                                phase = PH_DONE;
                                hex_letter = 1'b0;
                            end
                        end
                        else
                            fail_both();
                    default:
                        ;
                endcase
            end
            if (!last)
                return;

            v4ok = !v4_bad;
            v6ok = !v6_bad;
            tail = 1'b0;
            case (phase)
                PH_HEX:
                begin
                    v4ok = 1'b0;
                    close_group();
                    v6ok = v6ok && !v6_bad;
                end
                PH_DEC:
                    if (dec_run <= DEC_MAX && quad_idx == 2'd3)
                    begin
                        put_octet();
                        tail = 1'b1;
                    end
                    else
                    begin
                        v4ok = 1'b0;
                        v6ok = 1'b0;
                    end
                PH_DONE:
                    tail = 1'b1;
                PH_GAP:
                    v4ok = 1'b0;
                default:
                begin
                    v4ok = 1'b0;
                    v6ok = 1'b0;
                end
            endcase
            v4ok = v4ok && tail;

            // a dotted tail stands for two groups
            cnt = int'(grp_cnt) + (tail ? 2 : 0);
            if (gap_hit)
            begin
                if (cnt > 7)
                    v6ok = 1'b0;
            end
            else if (cnt != 8)
                v6ok = 1'b0;

            hi = 64'd0;
            lo = 64'd0;
            fam = FAM_NONE;
            if (v6ok)
            begin
                for (int i = 0; i < 8; i++)
                    lst[i] = 16'h0;
                for (int i = 0; i < int'(grp_cnt) && i < 8; i++)
                    lst[i] = grp[i];
                if (tail && grp_cnt <= 4'd6)
                begin
                    lst[int'(grp_cnt) & 7] = quad[31:16];
                    lst[(int'(grp_cnt) + 1) & 7] = quad[15:0];
                end
                fill = gap_hit ? 8 - cnt : 0;
                for (int i = 0; i < 8; i++)
                    if (!gap_hit || i < int'(gap_at))
                        w[i] = lst[i];
                    else if (i < int'(gap_at) + fill)
                        w[i] = 16'h0;
                    else
                        w[i] = lst[(i - fill) & 7];
                for (int i = 0; i < 4; i++)
                begin
                    hi = {hi[47:0], w[i]};
                    lo = {lo[47:0], w[i + 4]};
                end
                fam = FAM_V6;
                n_v6++;
            end
            else if (v4ok)
            begin
                lo = {32'd0, quad};
                fam = FAM_V4;
                n_v4++;
            end
            else
                n_bad++;

            r.ok = (fam != FAM_NONE);
            r.family = fam;
            r.addr_hi = hi;
            r.addr_lo = lo;
            want_q.push_back(r);
            strings++;
            clear();
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_beat(logic [135:0] data);
            result_t want;
            result_t got;

            if (want_q.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing pending, expected none, actual %h",
                         $time, data);
                return;
            end
            want = want_q.pop_front();
            got = data[130:0];
            compare("ok", 64'(want.ok), 64'(got.ok));
            compare("family", 64'(want.family), 64'(got.family));
            compare("addr_hi", want.addr_hi, got.addr_hi);
            compare("addr_lo", want.addr_lo, got.addr_lo);
            compare("pad", 64'd0, 64'(data[135:131]));
        endfunction
    endclass

endpackage

@@ verif/ip_address_text_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench top for the ip address text parser: character stimulus, stalls and result checks
module ip_address_text_parser_unit_tb;
    import ipatp_pkg::*;
    import ipatp_check_pkg::*;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;   // ch[7:0]
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;           // ok, family[2:1], addr_hi[66:3], addr_lo[130:67], zero

    addr_parse_scoreboard sb = new();
    logic [7:0] txt[$];
    int         burst_left = 0;
    int         rx_cycle = 0;

    ip_address_text_parser_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver stalls: free running, random, short windows, rare pulses
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata);
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ((rx_cycle % 11) < 3);
            default: m_tready <= ((rx_cycle % 16) == 0);
        endcase
    end

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0:       return CH_COLON;
            1:       return CH_DOT;
            2:       return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
            3:       return 8'($urandom_range(48, 57));
            4:       return 8'($urandom_range(0, 1) ? $urandom_range(97, 102)
                                                     : $urandom_range(65, 70));
            5:       return 8'h78;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
    endtask

    task automatic send_beat(logic [7:0] c, logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(c, l);
        burst_left--;
    endtask

    task automatic send_text();
        for (int i = 0; i < txt.size(); i++)
            send_beat(txt[i], i == txt.size() - 1);
        txt.delete();
    endtask

    task automatic run_text(string s);
        add_str(s);
        send_text();
    endtask

    task automatic add_v4();
        int    v;
        string d;
        for (int j = 0; j < 4; j++)
        begin
            if (j > 0)
                add_str(".");
            case ($urandom_range(0, 19))
                0, 1:    v = 0;
                2, 3:    v = 255;
                19:      v = $urandom_range(256, 99999);
                default: v = $urandom_range(0, 255);
            endcase
            d = $sformatf("%0d", v);
            if ($urandom_range(0, 7) == 0)
                d = {"0", d};
            add_str(d);
        end
        // whitespace ends the quad, anything after it is don't-care
        if ($urandom_range(0, 4) == 0)
        begin
            add_str($urandom_range(0, 1) ? " " : "\t");
            repeat ($urandom_range(0, 3))
                txt.push_back(pick_char());
        end
    endtask

    task automatic add_v6();
        bit    tail;
        bit    gap;
        int    slots;
        int    k;
        int    p;
        int    v;
        string g;
        tail = ($urandom_range(0, 3) == 0);
        gap = 1'($urandom_range(0, 1));
        slots = tail ? 6 : 8;
        k = gap ? $urandom_range(0, slots - 1) : slots;
        if ($urandom_range(0, 9) == 0)
            k = (k > 0 && $urandom_range(0, 1)) ? k - 1 : k + 1;
        p = $urandom_range(0, k);
        for (int i = 0; i < k; i++)
        begin
            if (gap && i == p)
                add_str("::");
            else if (i > 0)
                add_str(":");
            case ($urandom_range(0, 19))
                0, 1:    v = 0;
                2, 3:    v = 16'hffff;
                4, 5, 6: v = $urandom_range(0, 15);
                19:      v = $urandom_range(32'h10000, 32'hfffff);
                default: v = $urandom_range(0, 16'hffff);
            endcase
            g = $sformatf("%0h", v);
            if ($urandom_range(0, 1))
                g = g.toupper();
            if ($urandom_range(0, 7) == 0)
                g = {"0", g};
            add_str(g);
        end
        if (gap && p == k)
            add_str("::");
        else if (tail)
            add_str(":");
        if (tail)
            add_v4();
    endtask

    task automatic mutate();
        int pos;
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
            0: txt[pos] = pick_char();
            1: txt.insert(pos, pick_char());
            default:
                if (txt.size() > 1)
                    txt.delete(pos);
                else
                    txt[pos] = pick_char();
        endcase
    endtask

    initial
    begin
        int rnd_chars;
        int rnd_strings;
        int r;
        int waited;

        rnd_chars = 0;
        rnd_strings = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        run_text("1:2:3:4:5:6:7:8");
        run_text("ffff:FFFF:ffff:FfFf:ffff:ffff:ffff:ffff");
        run_text("::");
        run_text("1::");
        run_text(":1::2");
        run_text(":::1");
        run_text("1::2::3");
        run_text("1:2:3:4:5:6:7:");
        run_text("1:2:3:4:5:6:7:8:9");
        run_text("1::2:3:4:5:6:7:8");
        run_text("10000::1");
        run_text("0000000ab::1");
        run_text("::ffff:192.168.0.1 zz");
        run_text("1:2:3:4:5:6:1.2.3.4");
        run_text("1:2:3:4:5:6:7:1.2.3.4");
        run_text("a1.2.3.4");
        run_text("255.255.255.255");
        run_text("0.0.0.0");
        run_text("256.1.1.99999");
        run_text("1.2.3.4\tx:y");
        run_text("1.2.3");
        run_text("+1.2.3.4");
        run_text("0x1.2.3.4");
        txt.push_back(8'h00);
        send_text();
        txt.push_back(8'hff);
        add_str("::1");
        send_text();

        // mostly well-formed addresses with random content, some broken, some noise
        while (rnd_chars < 200)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                add_v6();
            else if (r < 70)
                add_v4();
            else if (r < 90)
            begin
                if ($urandom_range(0, 1))
                    add_v6();
                else
                    add_v4();
                mutate();
            end
            else
                repeat ($urandom_range(1, 6))
                    txt.push_back(pick_char());
            rnd_chars += txt.size();
            rnd_strings++;
            send_text();
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (sb.want_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (sb.want_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.want_q.size());
            sb.errors++;
        end

        $display("parsed %0d strings from %0d character beats (%0d random strings)",
                 sb.strings, sb.chars, rnd_strings);
        $display("valid ipv6 %0d, valid ipv4 %0d, rejected %0d, mismatches %0d",
                 sb.n_v6, sb.n_v4, sb.n_bad, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("%0t: run did not complete in time", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
